// ===== hw/rtl/sjfq_pkg.sv =====
`timescale 1ns / 1ps

package sjfq_pkg;

    localparam int QUEUE_DEPTH_DEF = 8;

    localparam int ID_W    = 8;
    localparam int BURST_W = 16;
    localparam int TIME_W  = 32;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 4;

    // result codes
    localparam logic [STAT_W-1:0] ST_INSERTED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_DISPATCHED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL       = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd3;

    // item kinds
    localparam logic KIND_INSERT   = 1'b0;
    localparam logic KIND_DISPATCH = 1'b1;

    // queue operations
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_INSERT = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    typedef struct packed {
        logic              capture;
        logic              load_out;
        logic [1:0]        op;
        logic [STAT_W-1:0] code;
    } t_dp_cmd;

    typedef struct packed {
        logic kind;
        logic full;
        logic empty;
    } t_dp_stat;

endpackage

// ===== hw/rtl/sjfq_ctrl.sv =====
`timescale 1ns / 1ps

module sjfq_ctrl
    import sjfq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    output logic     o_in_stall,
    output logic     o_out_valid,
    input  logic     i_out_stall,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_accept;
    logic w_out_free;

    assign o_in_stall  = (r_state == S_EXEC);
    assign o_out_valid = r_out_valid;
    assign w_accept    = i_in_valid && (r_state == S_IDLE);
    assign w_out_free  = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid && i_out_stall;
        o_cmd        = '0;
        o_cmd.op     = OP_NONE;
        o_cmd.code   = ST_INSERTED;
        o_cmd.capture = w_accept;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                    if (i_stat.kind == KIND_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.code = ST_FULL;
                        end else begin
                            o_cmd.code = ST_INSERTED;
                            o_cmd.op   = OP_INSERT;
                        end
                    end else begin
                        if (i_stat.empty) begin
                            o_cmd.code = ST_EMPTY;
                        end else begin
                            o_cmd.code = ST_DISPATCHED;
                            o_cmd.op   = OP_REMOVE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    a_accept_to_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_state == S_EXEC)
        else $error("accepted item did not enter exec");

    a_no_insert_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_INSERT |-> !i_stat.full)
        else $error("insert issued into full queue");

    a_no_remove_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.op == OP_REMOVE |-> !i_stat.empty)
        else $error("remove issued from empty queue");

    a_exec_completes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && w_out_free) |=> (o_out_valid && r_state == S_IDLE))
        else $error("exec did not produce a result");

endmodule

// ===== hw/rtl/sjfq_dp.sv =====
`timescale 1ns / 1ps

module sjfq_dp
    import sjfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_job_id,
    input  logic [BURST_W-1:0] i_burst_time,
    input  logic [TIME_W-1:0]  i_now_time,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic [STAT_W-1:0]  o_status,
    output logic [ID_W-1:0]    o_out_job_id,
    output logic [BURST_W-1:0] o_out_burst,
    output logic [TIME_W-1:0]  o_response_time,
    output logic [OCC_W-1:0]   o_occupancy
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    // captured item
    logic               r_kind;
    logic [ID_W-1:0]    r_id;
    logic [BURST_W-1:0] r_burst;
    logic [TIME_W-1:0]  r_now;

    // sorted shift queue, head at cell 0
    logic [BURST_W-1:0] r_burst_q [QUEUE_DEPTH];
    logic [ID_W-1:0]    r_id_q    [QUEUE_DEPTH];
    logic [TIME_W-1:0]  r_arr_q   [QUEUE_DEPTH];
    logic [CNT_W-1:0]   r_count, n_count;

    // cells that hold a job not longer than the new one
    logic [QUEUE_DEPTH-1:0] w_le;

    // result registers
    logic [STAT_W-1:0]  r_status;
    logic [ID_W-1:0]    r_out_id;
    logic [BURST_W-1:0] r_out_burst;
    logic [TIME_W-1:0]  r_resp;
    logic [CNT_W-1:0]   r_occ;

    always_comb begin
        for (int k = 0; k < QUEUE_DEPTH; k++) begin
            w_le[k] = (CNT_W'(k) < r_count) && (r_burst_q[k] <= r_burst);
        end
    end

    assign o_stat.kind  = r_kind;
    assign o_stat.full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        case (i_cmd.op)
            OP_INSERT: n_count = r_count + CNT_W'(1);
            OP_REMOVE: n_count = r_count - CNT_W'(1);
            default:   n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_kind  <= i_kind;
            r_id    <= i_job_id;
            r_burst <= i_burst_time;
            r_now   <= i_now_time;
        end
    end

    genvar g;
    generate
        for (g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
            logic w_take_new;
            logic w_take_prev;
            if (g == 0) begin : g_head
                assign w_take_new  = !w_le[g];
                assign w_take_prev = 1'b0;
            end else begin : g_body
                assign w_take_new  = !w_le[g] && w_le[g-1];
                assign w_take_prev = !w_le[g] && !w_le[g-1];
            end

            always_ff @(posedge i_clk) begin
                if (i_cmd.op == OP_INSERT) begin
                    if (w_take_new) begin
                        r_burst_q[g] <= r_burst;
                        r_id_q[g]    <= r_id;
                        r_arr_q[g]   <= r_now;
                    end else if (w_take_prev) begin
                        if (g > 0) begin
                            r_burst_q[g] <= r_burst_q[(g > 0) ? g - 1 : 0];
                            r_id_q[g]    <= r_id_q[(g > 0) ? g - 1 : 0];
                            r_arr_q[g]   <= r_arr_q[(g > 0) ? g - 1 : 0];
                        end
                    end
                end else if (i_cmd.op == OP_REMOVE) begin
                    if (g < QUEUE_DEPTH - 1) begin
                        r_burst_q[g] <= r_burst_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                        r_id_q[g]    <= r_id_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                        r_arr_q[g]   <= r_arr_q[(g < QUEUE_DEPTH - 1) ? g + 1 : g];
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_status <= i_cmd.code;
            r_occ    <= n_count;
            if (i_cmd.op == OP_REMOVE) begin
                r_out_id    <= r_id_q[0];
                r_out_burst <= r_burst_q[0];
                r_resp      <= r_now - r_arr_q[0];
            end else begin
                r_out_id    <= '0;
                r_out_burst <= '0;
                r_resp      <= '0;
            end
        end
    end

    assign o_status        = r_status;
    assign o_out_job_id    = r_out_id;
    assign o_out_burst     = r_out_burst;
    assign o_response_time = r_resp;
    assign o_occupancy     = OCC_W'(r_occ);

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(QUEUE_DEPTH))
        else $error("job count above queue depth");

    a_insert_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_INSERT |-> r_count < CNT_W'(QUEUE_DEPTH))
        else $error("insert with no free cell");

    a_remove_has_job: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.op == OP_REMOVE |-> r_count != '0)
        else $error("remove with no job waiting");

endmodule

// ===== hw/rtl/shortest_job_first_queue.sv =====
`timescale 1ns / 1ps
// result: the result register loads in the exec state after the input transfer, once the output register is free
// the block takes no new item while in exec (input transfer, then exec); a stalled result holds exec
// a new item is taken while the previous result still waits in the output register
// reset: synchronous active-low i_rst_n empties the queue and drops any pending result
// queue entries hold no reset value; only entries below the job count are ever read

module shortest_job_first_queue
    import sjfq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_kind,
    input  logic [ID_W-1:0]    i_job_id,
    input  logic [BURST_W-1:0] i_burst_time,
    input  logic [TIME_W-1:0]  i_now_time,
    // result channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [STAT_W-1:0]  o_status,
    output logic [ID_W-1:0]    o_out_job_id,
    output logic [BURST_W-1:0] o_out_burst,
    output logic [TIME_W-1:0]  o_response_time,
    output logic [OCC_W-1:0]   o_occupancy
);

    // controller to datapath commands and datapath flags back
    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    // controller: idle/exec sequencer, owns both handshakes and picks the
    // queue operation and result code from the item kind and full/empty flags
    sjfq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // datapath: sorted shift queue where every cell compares its burst with
    // the new job in parallel; insert shifts the tail back one cell, dispatch
    // shifts the whole queue toward the head
    sjfq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_kind          (i_kind),
        .i_job_id        (i_job_id),
        .i_burst_time    (i_burst_time),
        .i_now_time      (i_now_time),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .o_status        (o_status),
        .o_out_job_id    (o_out_job_id),
        .o_out_burst     (o_out_burst),
        .o_response_time (o_response_time),
        .o_occupancy     (o_occupancy)
    );

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import sjfq_pkg::*;

    localparam int DEPTH = QUEUE_DEPTH_DEF;

    // one result as it leaves the block
    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [ID_W-1:0]    job_id;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  resp;
        logic [OCC_W-1:0]   occ;
    } t_reply;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic               i_kind;
    logic [ID_W-1:0]    i_job_id;
    logic [BURST_W-1:0] i_burst_time;
    logic [TIME_W-1:0]  i_now_time;
    logic               o_out_valid;
    logic               i_out_stall;
    logic [STAT_W-1:0]  o_status;
    logic [ID_W-1:0]    o_out_job_id;
    logic [BURST_W-1:0] o_out_burst;
    logic [TIME_W-1:0]  o_response_time;
    logic [OCC_W-1:0]   o_occupancy;

    // shadow copy of the job queue, sorted by burst, oldest first among ties
    logic [BURST_W-1:0] shadow_burst   [DEPTH];
    logic [ID_W-1:0]    shadow_id      [DEPTH];
    logic [TIME_W-1:0]  shadow_arrival [DEPTH];
    int                 shadow_count;

    // replies owed by the block, oldest at the front
    t_reply replies_due [$];

    int  err_count;
    bit  in_idle_en;    // random gaps between input transfers
    bit  out_idle_en;   // random stall on the result side
    int  stall_hold;
    logic [TIME_W-1:0] wall_ms;

    shortest_job_first_queue #(
        .QUEUE_DEPTH(DEPTH)
    ) u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_kind          (i_kind),
        .i_job_id        (i_job_id),
        .i_burst_time    (i_burst_time),
        .i_now_time      (i_now_time),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_out_job_id    (o_out_job_id),
        .o_out_burst     (o_out_burst),
        .o_response_time (o_response_time),
        .o_occupancy     (o_occupancy)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // apply one accepted item to the shadow queue and return the reply it owes
    function automatic t_reply sjf_apply(input logic kind, input logic [ID_W-1:0] id,
                                         input logic [BURST_W-1:0] burst,
                                         input logic [TIME_W-1:0] now);
        t_reply r;
        int     pos;
        r = '0;
        if (kind == KIND_INSERT) begin
            if (shadow_count >= DEPTH) begin
                r.status = ST_FULL;
            end else begin
                // new job goes behind every job with burst <= its own
                pos = 0;
                while (pos < shadow_count && shadow_burst[pos] <= burst)
                    pos++;
                for (int k = shadow_count; k > pos; k--) begin
                    shadow_burst[k]   = shadow_burst[k-1];
                    shadow_id[k]      = shadow_id[k-1];
                    shadow_arrival[k] = shadow_arrival[k-1];
                end
                shadow_burst[pos]   = burst;
                shadow_id[pos]      = id;
                shadow_arrival[pos] = now;
                shadow_count++;
                r.status = ST_INSERTED;
            end
        end else begin
            if (shadow_count == 0) begin
                r.status = ST_EMPTY;
            end else begin
                r.status = ST_DISPATCHED;
                r.job_id = shadow_id[0];
                r.burst  = shadow_burst[0];
                r.resp   = now - shadow_arrival[0];   // wraps modulo 2^32
                for (int k = 1; k < shadow_count; k++) begin
                    shadow_burst[k-1]   = shadow_burst[k];
                    shadow_id[k-1]      = shadow_id[k];
                    shadow_arrival[k-1] = shadow_arrival[k];
                end
                shadow_count--;
            end
        end
        r.occ = shadow_count[OCC_W-1:0];
        return r;
    endfunction

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 20);
    endfunction

    // one input transfer: drive at the falling edge, wait for acceptance
    task automatic send_item(input logic kind, input logic [ID_W-1:0] id,
                             input logic [BURST_W-1:0] burst,
                             input logic [TIME_W-1:0] now);
        int gap;
        @(negedge i_clk);
        i_in_valid   = 1'b1;
        i_kind       = kind;
        i_job_id     = id;
        i_burst_time = burst;
        i_now_time   = now;
        do
            @(posedge i_clk);
        while (o_in_stall);
        // transfer happened at this edge
        replies_due.push_back(sjf_apply(kind, id, burst, now));
        gap = in_idle_en ? pick_gap() : 0;
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // result side stall, alternating stalled and open stretches
    always @(negedge i_clk) begin
        if (!out_idle_en) begin
            i_out_stall = 1'b0;
            stall_hold  = 0;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else if ($urandom_range(0, 99) < 30) begin
            i_out_stall = 1'b1;
            stall_hold  = pick_gap();
        end else begin
            i_out_stall = 1'b0;
            stall_hold  = $urandom_range(1, 6);
        end
    end

    // compare every result transfer with the oldest reply owed
    always @(posedge i_clk) begin : result_check
        t_reply got;
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_status, o_out_job_id, o_out_burst, o_response_time, o_occupancy};
            if (replies_due.size() == 0) begin
                err_count++;
                if (err_count <= 40)
                    $display("%0t: result with nothing owed: st=%0d id=%0d burst=%0d",
                             $time, got.status, got.job_id, got.burst);
            end else begin
                want = replies_due.pop_front();
                if (got.status !== want.status || got.job_id !== want.job_id ||
                    got.burst !== want.burst || got.resp !== want.resp ||
                    got.occ !== want.occ) begin
                    err_count++;
                    if (err_count <= 40)
                        $display({"%0t: mismatch exp st=%0d id=%0d burst=%0d resp=%0d occ=%0d",
                                  " got st=%0d id=%0d burst=%0d resp=%0d occ=%0d"},
                                 $time, want.status, want.job_id, want.burst, want.resp,
                                 want.occ, got.status, got.job_id, got.burst, got.resp,
                                 got.occ);
                end
            end
        end
    end

    // dispatch with nothing waiting
    task automatic test_empty_dispatch();
        send_item(KIND_DISPATCH, 8'hFF, 16'hFFFF, 32'hFFFF_FFFF);
    endtask

    // ordering by burst, ties first-in first-out, full rejection, drain to empty
    task automatic test_order_and_full();
        send_item(KIND_INSERT, 8'd255, 16'hFFFF, 32'd0);
        send_item(KIND_INSERT, 8'd0,   16'd0,    32'd10);
        send_item(KIND_INSERT, 8'd11,  16'd100,  32'd20);
        send_item(KIND_INSERT, 8'd12,  16'd100,  32'd30);
        send_item(KIND_INSERT, 8'd13,  16'd100,  32'd40);
        send_item(KIND_INSERT, 8'd14,  16'd0,    32'd50);
        send_item(KIND_INSERT, 8'd15,  16'hFFFF, 32'd60);
        send_item(KIND_INSERT, 8'd16,  16'd50,   32'hFFFF_FFFF);
        // queue is full now
        send_item(KIND_INSERT, 8'hAA,  16'd1,    32'd70);
        for (int k = 0; k < DEPTH + 1; k++)
            send_item(KIND_DISPATCH, 8'h55, 16'h5555, 32'd1000 + k);
    endtask

    // response time across the 32-bit wrap
    task automatic test_time_wrap();
        send_item(KIND_INSERT,   8'd1, 16'd7, 32'hFFFF_FFF0);
        send_item(KIND_DISPATCH, 8'd0, 16'd0, 32'h0000_0010);
        send_item(KIND_INSERT,   8'd2, 16'd7, 32'h0000_0000);
        send_item(KIND_DISPATCH, 8'd0, 16'd0, 32'hFFFF_FFFF);
    endtask

    // random traffic that swings between filling and draining the queue
    task automatic test_random_traffic(input int n_items, input bit in_idle, input bit out_idle);
        bit                 lean_insert;
        logic               kind;
        logic [BURST_W-1:0] burst;
        logic [TIME_W-1:0]  now;
        int                 r;
        in_idle_en  = in_idle;
        out_idle_en = out_idle;
        lean_insert = 1'b1;
        for (int i = 0; i < n_items; i++) begin
            if (shadow_count >= DEPTH && $urandom_range(0, 99) < 80)
                lean_insert = 1'b0;
            else if (shadow_count == 0 && $urandom_range(0, 99) < 80)
                lean_insert = 1'b1;
            if ($urandom_range(0, 99) < 70)
                kind = lean_insert ? KIND_INSERT : KIND_DISPATCH;
            else
                kind = lean_insert ? KIND_DISPATCH : KIND_INSERT;
            // narrow bursts give plenty of ties
            r = $urandom_range(0, 99);
            if (r < 50)
                burst = BURST_W'($urandom_range(0, 7));
            else if (r < 85)
                burst = BURST_W'($urandom_range(0, 65535));
            else
                burst = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            // mostly a running clock, sometimes an arbitrary stamp
            wall_ms += $urandom_range(0, 500);
            now = ($urandom_range(0, 9) == 0) ? $urandom : wall_ms;
            send_item(kind, ID_W'($urandom_range(0, 255)), burst, now);
        end
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_in_valid   = 1'b0;
        i_kind       = KIND_INSERT;
        i_job_id     = '0;
        i_burst_time = '0;
        i_now_time   = '0;
        i_out_stall  = 1'b0;
        in_idle_en   = 1'b0;
        out_idle_en  = 1'b0;
        stall_hold   = 0;
        err_count    = 0;
        shadow_count = 0;
        wall_ms      = 32'hFFF0_0000;   // running clock starts near the top of the 32-bit range
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;

        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        test_empty_dispatch();
        test_order_and_full();
        test_time_wrap();
        test_random_traffic(450, 1'b1, 1'b1);
        test_random_traffic(200, 1'b0, 1'b0);
        test_random_traffic(100, 1'b1, 1'b0);
        test_random_traffic(100, 1'b0, 1'b1);

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (replies_due.size() == 0);
        repeat (8) @(posedge i_clk);
        if (err_count == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

    // overall time limit
    initial begin
        #2_000_000;
        $display("tb: errors");
        $finish;
    end

endmodule
